@@ sv/nbs_pkg.sv @@
// ----------------------------------------------------------------------------
// nbs_pkg
// Shared constants, types and the per-word noise count for bit_noise_score.
// ----------------------------------------------------------------------------
package nbs_pkg;

  // Default accumulator and fraction widths
  localparam int COUNT_BITS_DEF = 40;
  localparam int FRAC_BITS_DEF  = 16;

  // Word geometry
  localparam int WORD_W       = 64;
  localparam int CNT_W        = 4;
  localparam int BYTES_PER_W  = 8;
  localparam int PAIRS_PER_W  = 32;
  localparam int WNOISE_W     = 6;   // up to 8 top bits + 32 pairs = 40
  localparam int WINSP_W      = 6;   // up to 8 bytes * 4 = 32

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BYTES_PER_W);

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // Byte count saturated at eight
  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
    sat_count = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
  endfunction

  // Noise of one word: set top bits of valid bytes plus even positions whose
  // bit differs from the next higher one; invalid bytes count as zero.
  function automatic logic [WNOISE_W-1:0] word_noise(input logic [WORD_W-1:0] w,
                                                     input logic [CNT_W-1:0]  cnt);
    logic [WORD_W-1:0]   m;
    logic [WNOISE_W-1:0] n;
    m = w;
    n = '0;
    for (int b = 0; b < BYTES_PER_W; b++) begin
      if (CNT_W'(b) >= cnt) begin
        m[8*b +: 8] = 8'h00;
      end
    end
    for (int b = 0; b < BYTES_PER_W; b++) begin
      n = n + WNOISE_W'(m[8*b+7]);
    end
    for (int i = 0; i < PAIRS_PER_W; i++) begin
      n = n + WNOISE_W'(m[2*i] ^ m[2*i+1]);
    end
    word_noise = n;
  endfunction

endpackage

@@ sv/nbs_if.sv @@
// ----------------------------------------------------------------------------
// nbs_if
// Valid/ready channels for buffer words in and scores out.
// ----------------------------------------------------------------------------
interface nbs_in_if
  import nbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_data;
  logic [CNT_W-1:0]  byte_count;
  logic              last_word;

  modport source (output valid, output word_data, output byte_count,
                  output last_word, input ready);
  modport sink   (input valid, input word_data, input byte_count,
                  input last_word, output ready);
endinterface

interface nbs_out_if
  import nbs_pkg::*;
#(
  parameter int SCORE_W = FRAC_BITS_DEF + 1
) ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

@@ sv/nbs_front.sv @@
// ----------------------------------------------------------------------------
// nbs_front
// Takes buffer words, counts noise per word in a first stage, then keeps
// saturating running totals and hands both totals to the queue on a last word.
// ----------------------------------------------------------------------------
module nbs_front
  import nbs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  nbs_in_if.sink                  in_ch,
  input  logic                    q_full,
  output logic                    push,
  output logic [2*COUNT_BITS-1:0] push_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Stage 1 registers
  logic                s1_valid;
  logic [WNOISE_W-1:0] s1_noise;
  logic [WINSP_W-1:0]  s1_insp;
  logic                s1_last;

  // Running totals
  logic [COUNT_BITS-1:0] noise_total;
  logic [COUNT_BITS-1:0] inspected_bits;

  logic                  advance;
  logic [CNT_W-1:0]      cnt_sat;
  logic [COUNT_BITS:0]   noise_sum;
  logic [COUNT_BITS:0]   insp_sum;
  logic [COUNT_BITS-1:0] noise_new;
  logic [COUNT_BITS-1:0] insp_new;

  // A last word waits in stage 1 while the queue is full
  assign advance     = s1_valid && !(s1_last && q_full);
  assign in_ch.ready = !s1_valid || advance;
  assign cnt_sat     = sat_count(in_ch.byte_count);

  // Per-word counts
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_noise <= word_noise(in_ch.word_data, cnt_sat);
      s1_insp  <= {cnt_sat, 2'b00};
      s1_last  <= in_ch.last_word;
    end
  end

  // Saturating accumulate
  always_comb begin
    noise_sum = {1'b0, noise_total} + (COUNT_BITS+1)'(s1_noise);
    insp_sum  = {1'b0, inspected_bits} + (COUNT_BITS+1)'(s1_insp);
    noise_new = noise_sum[COUNT_BITS] ? COUNT_MAX : noise_sum[COUNT_BITS-1:0];
    insp_new  = insp_sum[COUNT_BITS] ? COUNT_MAX : insp_sum[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_total    <= '0;
      inspected_bits <= '0;
    end else if (advance) begin
      if (s1_last) begin
        noise_total    <= '0;
        inspected_bits <= '0;
      end else begin
        noise_total    <= noise_new;
        inspected_bits <= insp_new;
      end
    end
  end

  // Totals of a finished buffer go to the back end
  assign push      = advance && s1_last;
  assign push_data = {noise_new, insp_new};

endmodule

@@ sv/nbs_queue.sv @@
// ----------------------------------------------------------------------------
// nbs_queue
// Two-entry queue of finished buffer totals between front and back end.
// ----------------------------------------------------------------------------
module nbs_queue
  import nbs_pkg::*;
#(
  parameter int DATA_W = 2 * COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output logic [DATA_W-1:0] head
);

  localparam int DEPTH = 2;

  logic [DATA_W-1:0] entry [DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign full      = (fill == 2'(DEPTH));
  assign not_empty = (fill != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/nbs_back.sv @@
// ----------------------------------------------------------------------------
// nbs_back
// Turns buffer totals into a clamped fixed-point ratio with a restoring
// divider, one quotient bit per cycle, and holds it in an output register.
// ----------------------------------------------------------------------------
module nbs_back
  import nbs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_not_empty,
  input  logic [2*COUNT_BITS-1:0] q_head,
  output logic                    pop,
  nbs_out_if.source               out_ch
);

  localparam int SCORE_W = FRAC_BITS + 1;
  localparam int STEP_W  = $clog2(FRAC_BITS);
  localparam logic [SCORE_W-1:0] SCORE_ONE  = SCORE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(FRAC_BITS - 1);

  back_state_t state, state_next;

  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] den;
  logic [SCORE_W-1:0]    quo;
  logic [STEP_W-1:0]     step;

  logic [COUNT_BITS-1:0] head_num;
  logic [COUNT_BITS-1:0] head_den;
  logic [COUNT_BITS:0]   rem2;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;
  logic                  out_free;
  logic                  load_out;

  assign head_num = q_head[2*COUNT_BITS-1:COUNT_BITS];
  assign head_den = q_head[COUNT_BITS-1:0];
  assign rem2     = {rem, 1'b0};
  assign diff     = rem2 - {1'b0, den};
  assign fits     = (rem2 >= {1'b0, den});
  assign out_free = !out_ch.valid || out_ch.ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_not_empty) begin
          pop = 1'b1;
          if (head_den == '0 || head_num >= head_den) begin
            state_next = B_DONE;
          end else begin
            state_next = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (step == LAST_STEP) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        rem  <= head_num;
        den  <= head_den;
        step <= '0;
        if (head_den == '0) begin
          quo <= '0;
        end else if (head_num >= head_den) begin
          quo <= SCORE_ONE;
        end else begin
          quo <= '0;
        end
      end
      B_DIV: begin
        step <= step + STEP_W'(1);
        if (fits) begin
          rem <= diff[COUNT_BITS-1:0];
          quo <= {quo[SCORE_W-2:0], 1'b1};
        end else begin
          rem <= rem2[COUNT_BITS-1:0];
          quo <= {quo[SCORE_W-2:0], 1'b0};
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.score <= quo;
    end
  end

endmodule

@@ sv/bit_noise_score.sv @@
// ----------------------------------------------------------------------------
// bit_noise_score
// Streaming bit-level noise ratio of a byte buffer.
// ----------------------------------------------------------------------------
// Words are taken at one per cycle. Each word's noise count is formed in a
// first stage and then added to saturating running totals; on a last word
// the two totals go into a two-entry queue and the totals clear. The back
// end pops one buffer at a time and runs a restoring divider that makes one
// quotient bit per cycle, so a score passes through a pop, FRAC_BITS divide
// steps and an output load, or only the pop and output load when nothing
// was inspected or the ratio reaches one. Input stalls only when a last word
// meets a full queue, so when buffers end faster than the back end makes
// scores, the divider sets the pace. A score that is not taken holds the
// back end in its output-load state; the queue then absorbs up to two more
// finished buffers before a last word stalls the input.
module bit_noise_score
  import nbs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nbs_in_if.sink     in_ch,
  nbs_out_if.source  out_ch
);

  localparam int QDATA_W = 2 * COUNT_BITS;

  logic               push;
  logic [QDATA_W-1:0] push_data;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;
  logic [QDATA_W-1:0] q_head;

  nbs_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  nbs_queue #(
    .DATA_W (QDATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  nbs_back #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_full || pop))
    else $error("totals pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("pop from an empty queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> q_full)
    else $error("input stalled while the queue has room");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.score <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
    else $error("score above one");

endmodule
